[src/sha1_stream_hasher_top_macros.svh]
// Assertion macros for the streaming hasher.
// SHA1SH_ASSERT checks only outside reset; SHA1SH_ASSERT_ANY checks on every edge.
`ifndef SHA1_STREAM_HASHER_TOP_MACROS_SVH
`define SHA1_STREAM_HASHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SHA1SH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHA1SH_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA1SH_ASSERT(lbl, prop, msg)
`define SHA1SH_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

[src/sha1sh_pkg.sv]
`default_nettype none
package sha1sh_pkg;

  localparam int COUNT_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int LEN_W           = 64;
  localparam int DIGEST_WORDS    = 5;

  // Largest fill position whose pad still leaves room for the length field.
  localparam logic [5:0] PAD_LIMIT = 6'd55;

  typedef enum logic {
    KIND_ABSORB,
    KIND_FINISH
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [5:0]        pos;
    logic [7:0]        data;
    logic [LEN_W-1:0]  bit_len;
  } cmd_t;

endpackage
`default_nettype wire

[src/sha1sh_front.sv]
`default_nettype none
module sha1sh_front #(
  parameter int COUNT_BITS = sha1sh_pkg::COUNT_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               op,
  input  wire  [7:0]        data_byte,
  input  wire               q_full,
  output logic              q_push,
  output sha1sh_pkg::cmd_t  q_cmd
);

  logic [5:0]            fill;
  logic [COUNT_BITS-1:0] count;
  logic                  accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Tag each item with its block position and, for finish, the bit length.
  always_comb begin
    q_cmd.kind    = op ? sha1sh_pkg::KIND_FINISH : sha1sh_pkg::KIND_ABSORB;
    q_cmd.pos     = fill;
    q_cmd.data    = data_byte;
    q_cmd.bit_len = sha1sh_pkg::LEN_W'(count) << 3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
    end else if (accept) begin
      if (op) begin
        fill  <= '0;
        count <= '0;
      end else begin
        fill  <= fill + 6'd1;
        count <= count + COUNT_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/sha1sh_queue.sv]
`default_nettype none
module sha1sh_queue #(
  parameter int DEPTH = sha1sh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  sha1sh_pkg::cmd_t  push_cmd,
  output logic              full,
  input  wire               pop,
  output logic              empty,
  output sha1sh_pkg::cmd_t  pop_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sha1sh_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill_cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill_cnt == CNT_W'(DEPTH));
  assign empty   = (fill_cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill_cnt <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_cnt <= fill_cnt + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_cnt <= fill_cnt - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/sha1sh_back.sv]
`default_nettype none
module sha1sh_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               q_empty,
  input  sha1sh_pkg::cmd_t  q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [31:0]       digest_word,
  output logic              word_last
);

  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [2:0]  LAST_WORD  = 3'(sha1sh_pkg::DIGEST_WORDS - 1);
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                     32'h10325476, 32'hC3D2E1F0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_EXTRA,
    PH_FINAL
  } phase_t;

  state_t      state;
  phase_t      phase;
  logic [6:0]  rnd;
  logic [2:0]  emit_idx;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] blk [16];
  logic [sha1sh_pkg::LEN_W-1:0] len_hold;

  logic [3:0]  wi;
  logic [1:0]  sub;
  logic [31:0] cur_word;
  logic [31:0] byte_word;
  logic [31:0] pad_word;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] w_new;
  logic [31:0] temp;
  logic        slot_free;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign slot_free = !out_valid || !out_stall;
  assign wi        = q_cmd.pos[5:2];
  assign sub       = q_cmd.pos[1:0];
  assign cur_word  = blk[wi];

  // Merge the byte big-endian; pad keeps earlier bytes and places 0x80 after them.
  always_comb begin
    unique case (sub)
      2'd0: begin
        byte_word = {q_cmd.data, 24'h0};
        pad_word  = {8'h80, 24'h0};
      end
      2'd1: begin
        byte_word = {cur_word[31:24], q_cmd.data, cur_word[15:0]};
        pad_word  = {cur_word[31:24], 8'h80, 16'h0};
      end
      2'd2: begin
        byte_word = {cur_word[31:16], q_cmd.data, cur_word[7:0]};
        pad_word  = {cur_word[31:16], 8'h80, 8'h0};
      end
      default: begin
        byte_word = {cur_word[31:8], q_cmd.data};
        pad_word  = {cur_word[31:8], 8'h80};
      end
    endcase
  end

  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  // Message schedule runs as a 16-word shift window; blk[0] is the current word.
  assign w_new = {blk[13][30:0] ^ blk[8][30:0] ^ blk[2][30:0] ^ blk[0][30:0],
                  blk[13][31] ^ blk[8][31] ^ blk[2][31] ^ blk[0][31]};
  assign temp  = {a[26:0], a[31:27]} + f + e + k + blk[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_DATA;
      rnd       <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= IV[i];
      end
    end else begin
      if (!out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_cmd.kind == sha1sh_pkg::KIND_ABSORB) begin
              blk[wi] <= byte_word;
              if (q_cmd.pos == 6'd63) begin
                phase <= PH_DATA;
                state <= S_LOAD;
              end
            end else begin
              len_hold <= q_cmd.bit_len;
              blk[wi]  <= pad_word;
              for (int i = 0; i < 14; i++) begin
                if (4'(i) > wi) begin
                  blk[i] <= '0;
                end
              end
              if (q_cmd.pos > sha1sh_pkg::PAD_LIMIT) begin
                // Clear the tail of the pad block; the length goes in the extra block.
                if (wi < 4'd14) begin
                  blk[14] <= '0;
                end
                if (wi < 4'd15) begin
                  blk[15] <= '0;
                end
                phase <= PH_EXTRA;
              end else begin
                blk[14] <= q_cmd.bit_len[63:32];
                blk[15] <= q_cmd.bit_len[31:0];
                phase   <= PH_FINAL;
              end
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          a     <= h[0];
          b     <= h[1];
          c     <= h[2];
          d     <= h[3];
          e     <= h[4];
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          e <= d;
          d <= c;
          c <= {b[1:0], b[31:2]};
          b <= a;
          a <= temp;
          for (int i = 0; i < 15; i++) begin
            blk[i] <= blk[i+1];
          end
          blk[15] <= w_new;
          rnd     <= rnd + 7'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          unique case (phase)
            PH_DATA: begin
              state <= S_IDLE;
            end
            PH_EXTRA: begin
              for (int i = 0; i < 14; i++) begin
                blk[i] <= '0;
              end
              blk[14] <= len_hold[63:32];
              blk[15] <= len_hold[31:0];
              phase   <= PH_FINAL;
              state   <= S_LOAD;
            end
            default: begin
              emit_idx <= '0;
              state    <= S_EMIT;
            end
          endcase
        end
        default: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            digest_word <= h[emit_idx];
            word_last   <= (emit_idx == LAST_WORD);
            if (emit_idx == LAST_WORD) begin
              for (int i = 0; i < 5; i++) begin
                h[i] <= IV[i];
              end
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 3'd1;
            end
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[src/sha1_stream_hasher_top.sv]
`default_nettype none
// Channel  Valid      Stall      Payload
// in       in_valid   in_stall   op, data_byte
// out      out_valid  out_stall  digest_word, word_last
//
// An absorb item is packed into the block in the engine; every 64th byte starts a
// compression (load, 80 rounds of the single round unit, chaining add).
// A finish item runs one compression, or two when the pad spills into an extra block,
// then hands out the five digest words; no new item is popped until the engine is idle.
// The input side takes one item per cycle while the item queue has room.
// rst is synchronous: it restores the initial vector and empties the queue.
// A stalled output word holds in its register; the engine waits on it unless it was the last word.
`include "sha1_stream_hasher_top_macros.svh"
module sha1_stream_hasher_top #(
  parameter int COUNT_BITS  = sha1sh_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = sha1sh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         op,
  input  wire  [7:0]  data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] digest_word,
  output logic        word_last
);

  // Items flow: front (counts, tags) -> queue -> back (pack, compress, emit).
  logic             q_push;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  sha1sh_pkg::cmd_t push_cmd;
  sha1sh_pkg::cmd_t pop_cmd;

  sha1sh_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sha1sh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  sha1sh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_last   (word_last)
  );

  // Engine only pops items that are present.
  `SHA1SH_ASSERT(a_pop_nonempty, q_pop |-> !q_empty, "pop from empty item queue")
  // An accepted item is queued by the next edge.
  `SHA1SH_ASSERT(a_accept_queued, (in_valid && !in_stall) |=> !q_empty, "accepted item lost")
  // Queue status never claims full and empty at once.
  `SHA1SH_ASSERT(a_full_empty, !(q_full && q_empty), "queue full and empty together")
  // Reset drops any pending digest word.
  `SHA1SH_ASSERT_ANY(a_rst_out, rst |=> !out_valid, "output valid after reset")

endmodule
`default_nettype wire
